@@ hdl/wua_pkg.sv @@
package wua_pkg;

  localparam int unsigned Width = 256;
  localparam int unsigned WordWidth = 64;

  localparam logic [2:0] ActAdd = 3'd0;
  localparam logic [2:0] ActSub = 3'd1;
  localparam logic [2:0] ActMul = 3'd2;
  localparam logic [2:0] ActDiv = 3'd3;
  localparam logic [2:0] ActShl = 3'd4;
  localparam logic [2:0] ActShr = 3'd5;

  localparam logic [1:0] StatOk = 2'd0;
  localparam logic [1:0] StatFlag = 2'd1;
  localparam logic [1:0] StatDivZero = 2'd2;

  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] a_word0;
    logic [63:0] a_word1;
    logic [63:0] a_word2;
    logic [63:0] a_word3;
    logic [63:0] b_word0;
    logic [63:0] b_word1;
    logic [63:0] b_word2;
    logic [63:0] b_word3;
    logic [7:0]  shift_amount;
  } req_t;

  typedef struct packed {
    logic [63:0] r_word0;
    logic [63:0] r_word1;
    logic [63:0] r_word2;
    logic [63:0] r_word3;
    logic [1:0]  status;
    logic        last;
  } rsp_t;

endpackage

@@ hdl/wide_unsigned_alu_256.sv @@
// Add and subtract are computed as the request is captured; shift moves one
// bit per step for shift_amount steps; multiply does one shift-add per
// multiplier bit; divide does one compare-subtract per quotient bit and gives
// the quotient, remainder next. One request at a time, until its result is taken.
// Reset (asynchronous, active low) returns the sequencer to idle.
module wide_unsigned_alu_256 (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  wua_pkg::req_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output wua_pkg::rsp_t   out_data_o
);
  import wua_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StOut  = 2'd2;

  logic [1:0]   state_q, state_d;
  logic [2:0]   act_q;
  logic [255:0] a_q, b_q, r_q, x_q;
  logic [8:0]   cnt_q;
  logic         flag_q, second_q;

  logic [256:0] sum;
  logic [256:0] rs;
  logic [256:0] dif;
  logic         bzero;
  logic [255:0] ain, bin;

  assign ain = {in_data_i.a_word3, in_data_i.a_word2, in_data_i.a_word1, in_data_i.a_word0};
  assign bin = {in_data_i.b_word3, in_data_i.b_word2, in_data_i.b_word1, in_data_i.b_word0};
  assign bzero = (b_q == '0);

  always_comb begin
    sum = {1'b0, r_q} + {1'b0, x_q};
    rs = {r_q, a_q[255]};
    dif = rs - {1'b0, b_q};
  end

  assign in_stall_o = (state_q != StIdle);
  assign out_valid_o = (state_q == StOut);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (in_valid_i) state_d = StRun;
      StRun: if (cnt_q == '0) state_d = StOut;
      StOut: if (!out_stall_i && (act_q != ActDiv || second_q)) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q <= '0;
      second_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StIdle && in_valid_i) begin
        second_q <= 1'b0;
        case (in_data_i.action)
          ActMul, ActDiv: cnt_q <= 9'd256;
          ActShl, ActShr: cnt_q <= {1'b0, in_data_i.shift_amount};
          default: cnt_q <= '0;
        endcase
      end else if (state_q == StRun && cnt_q != '0) begin
        cnt_q <= cnt_q - 9'd1;
      end else if (state_q == StOut && !out_stall_i) begin
        second_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i) begin
      act_q <= in_data_i.action;
      a_q <= ain;
      b_q <= bin;
      x_q <= ain;
      case (in_data_i.action)
        ActAdd: begin
          {flag_q, r_q} <= {1'b0, ain} + {1'b0, bin};
        end
        ActSub: begin
          {flag_q, r_q} <= {1'b0, ain} - {1'b0, bin};
        end
        ActShl, ActShr: begin
          r_q <= ain;
          flag_q <= 1'b0;
        end
        default: begin
          r_q <= '0;
          flag_q <= 1'b0;
        end
      endcase
    end else if (state_q == StRun && cnt_q != '0) begin
      case (act_q)
        ActMul: begin
          if (b_q[0]) r_q <= sum[255:0];
          flag_q <= flag_q | (b_q[0] & sum[256]) | (x_q[255] & (b_q[255:1] != '0));
          x_q <= {x_q[254:0], 1'b0};
          b_q <= {1'b0, b_q[255:1]};
        end
        ActDiv: begin
          a_q <= {a_q[254:0], 1'b0};
          if (!dif[256]) begin
            r_q <= dif[255:0];
            x_q <= {x_q[254:0], 1'b1};
          end else begin
            r_q <= rs[255:0];
            x_q <= {x_q[254:0], 1'b0};
          end
        end
        ActShl: r_q <= {r_q[254:0], 1'b0};
        ActShr: r_q <= {1'b0, r_q[255:1]};
        default: r_q <= r_q;
      endcase
    end else if (state_q == StRun && act_q == ActDiv) begin
      flag_q <= bzero;
    end
  end

  logic [255:0] res;
  always_comb begin
    res = r_q;
    out_data_o.status = flag_q ? StatFlag : StatOk;
    out_data_o.last = 1'b1;
    if (act_q == ActDiv) begin
      out_data_o.last = second_q;
      out_data_o.status = flag_q ? StatDivZero : StatOk;
      res = flag_q ? '0 : (second_q ? r_q : x_q);
    end else if (act_q > ActShr) begin
      res = '0;
      out_data_o.status = StatOk;
    end
    out_data_o.r_word0 = res[63:0];
    out_data_o.r_word1 = res[127:64];
    out_data_o.r_word2 = res[191:128];
    out_data_o.r_word3 = res[255:192];
  end

endmodule
